// File: hdl/assert_macros.svh
// Concurrent assertion helpers, clocked on i_clk and held off during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define RHC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("rhc check failed");

// Next-cycle implication.
`define RHC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("rhc check failed");

`endif

// File: hdl/rhc_pkg.sv
package rhc_pkg;

    localparam int DIV_W      = 32;
    localparam int NUM_W      = 41;   // phase * 360 fits here
    localparam int HUE_W      = 9;
    localparam int LVL_W      = 8;
    localparam int IDX_W      = 6;
    localparam int CNT_W      = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [DIV_W-1:0] DEFAULT_PERIOD = 32'd10000;
    localparam logic [CNT_W-1:0] STRIP_RESET    = 7'd64;
    localparam logic [LVL_W-1:0] FULL_LEVEL     = 8'd255;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PERIOD = 2'd0,
        CFG_STRIP  = 2'd1,
        CFG_BRIGHT = 2'd2
    } t_cfg_idx;

    typedef enum logic [2:0] {
        SEC_0 = 3'd0,
        SEC_1 = 3'd1,
        SEC_2 = 3'd2,
        SEC_3 = 3'd3,
        SEC_4 = 3'd4,
        SEC_5 = 3'd5
    } t_sector;

    // One slot of the restoring divider chain.
    typedef struct packed {
        logic             valid;
        logic [DIV_W-1:0] rem;
        logic [DIV_W-1:0] word;   // dividend bits out at the top, quotient bits in at the bottom
    } t_div_slot;

    typedef struct packed {
        logic             valid;
        logic [LVL_W-1:0] red;
        logic [LVL_W-1:0] green;
        logic [LVL_W-1:0] blue;
    } t_color;

endpackage

// File: hdl/rhc_ifs.sv
interface rhc_in_if import rhc_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [DIV_W-1:0] frame_time_ms;

    modport source (output valid, output frame_time_ms, input ready);
    modport sink (input valid, input frame_time_ms, output ready);
endinterface

interface rhc_pix_if import rhc_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] pixel_index;
    logic [LVL_W-1:0] red_level;
    logic [LVL_W-1:0] green_level;
    logic [LVL_W-1:0] blue_level;
    logic             last_pixel;

    modport source (output valid, output pixel_index, output red_level, output green_level,
                    output blue_level, output last_pixel, input ready);
    modport sink (input valid, input pixel_index, input red_level, input green_level,
                  input blue_level, input last_pixel, output ready);
endinterface

interface rhc_cfg_if import rhc_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// File: hdl/rhc_div_cell.sv
module rhc_div_cell import rhc_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_adv,
    input  logic [DIV_W-1:0] i_divisor,
    input  t_div_slot        i_slot,
    output t_div_slot        o_slot
);

    t_div_slot        r_slot;
    t_div_slot        n_slot;
    logic [DIV_W:0]   w_trial;
    logic [DIV_W:0]   w_diff;
    logic             w_ge;

    // One restoring step: bring in the next dividend bit, subtract if it fits.
    always_comb begin
        w_trial = {i_slot.rem, i_slot.word[DIV_W-1]};
        w_diff  = w_trial - {1'b0, i_divisor};
        w_ge    = (w_trial >= {1'b0, i_divisor});
        n_slot.valid = i_slot.valid;
        n_slot.rem   = w_ge ? w_diff[DIV_W-1:0] : w_trial[DIV_W-1:0];
        n_slot.word  = {i_slot.word[DIV_W-2:0], w_ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot.valid <= 1'b0;
        end else if (i_adv) begin
            r_slot <= n_slot;
        end
    end

    assign o_slot = r_slot;

endmodule

// File: hdl/rhc_color.sv
module rhc_color import rhc_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_adv,
    input  logic             i_valid,
    input  logic [HUE_W-1:0] i_hue,
    input  logic [LVL_W-1:0] i_value,
    output t_color           o_color
);

    logic             r_valid1;
    t_sector          r_sec1;
    logic [LVL_W-1:0] r_frac1;
    logic             r_valid2;
    t_sector          r_sec2;
    logic [15:0]      r_prod_t;
    logic [15:0]      r_prod_q;

    t_sector          n_sec;
    logic [HUE_W-1:0] w_base;
    logic [5:0]       w_rem60;
    logic [9:0]       w_frac_x4;
    logic [LVL_W-1:0] w_t;
    logic [LVL_W-1:0] w_q;

    // Exact x / 255 for any 16-bit product of two 8-bit levels.
    function automatic logic [LVL_W-1:0] div255(input logic [15:0] x);
        logic [16:0] s;
        s = {1'b0, x} + {9'd0, x[15:8]} + 17'd1;
        return s[15:8];
    endfunction

    // Hue to sector and fraction: f = (hue mod 60) * 17 / 4.
    always_comb begin
        if (i_hue >= 9'd300) begin
            n_sec = SEC_5; w_base = 9'd300;
        end else if (i_hue >= 9'd240) begin
            n_sec = SEC_4; w_base = 9'd240;
        end else if (i_hue >= 9'd180) begin
            n_sec = SEC_3; w_base = 9'd180;
        end else if (i_hue >= 9'd120) begin
            n_sec = SEC_2; w_base = 9'd120;
        end else if (i_hue >= 9'd60) begin
            n_sec = SEC_1; w_base = 9'd60;
        end else begin
            n_sec = SEC_0; w_base = 9'd0;
        end
        w_rem60   = 6'(i_hue - w_base);
        w_frac_x4 = {4'd0, w_rem60} * 10'd17;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid1 <= 1'b0;
            r_valid2 <= 1'b0;
        end else if (i_adv) begin
            r_valid1 <= i_valid;
            r_sec1   <= n_sec;
            r_frac1  <= w_frac_x4[9:2];
            r_valid2 <= r_valid1;
            r_sec2   <= r_sec1;
            r_prod_t <= 16'(i_value) * 16'(r_frac1);
            r_prod_q <= 16'(i_value) * 16'(FULL_LEVEL - r_frac1);
        end
    end

    always_comb begin
        w_t = div255(r_prod_t);
        w_q = div255(r_prod_q);
        o_color.valid = r_valid2;
        unique case (r_sec2)
            SEC_0: begin
                o_color.red = i_value; o_color.green = w_t; o_color.blue = '0;
            end
            SEC_1: begin
                o_color.red = w_q; o_color.green = i_value; o_color.blue = '0;
            end
            SEC_2: begin
                o_color.red = '0; o_color.green = i_value; o_color.blue = w_t;
            end
            SEC_3: begin
                o_color.red = '0; o_color.green = w_q; o_color.blue = i_value;
            end
            SEC_4: begin
                o_color.red = w_t; o_color.green = '0; o_color.blue = i_value;
            end
            default: begin
                o_color.red = i_value; o_color.green = '0; o_color.blue = w_q;
            end
        endcase
    end

endmodule

// File: hdl/rainbow_hue_cycle_pixel_fill_unit.sv
// Rainbow fill: each frame time item is reduced modulo the cycle period (10000 ms when the
// period register is zero), scaled to a hue of 0..359, turned into an RGB color at full
// saturation with the brightness register as value, and sent out as one pixel item per LED
// (strip_length, capped at MAX_LEDS, none for zero), the final one flagged by last_pixel.
// The arithmetic runs through a row of 41 identical restoring-divider cells (32 for the
// modulo, 9 for the hue quotient) plus a scale stage and two color stages. All stages
// advance together and stall while the pixel stage holds a frame, so an item is taken only
// in a cycle where that stage is idle or sending its last pixel. One pixel is sent per cycle
// while the receiver is ready, and many frame items can be in the pipeline at once.
`include "assert_macros.svh"

module rainbow_hue_cycle_pixel_fill_unit import rhc_pkg::*; #(
    parameter int MAX_LEDS = 64
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    rhc_in_if.sink    i_in,
    rhc_cfg_if.sink   i_cfg,
    rhc_pix_if.source o_pix
);

    localparam int MOD_STEPS = DIV_W;
    localparam int HUE_STEPS = HUE_W;

    logic [DIV_W-1:0] r_period;
    logic [CNT_W-1:0] r_strip;
    logic [LVL_W-1:0] r_bright;

    logic             r_scale_valid;
    logic [NUM_W-1:0] r_scale_num;

    logic             r_busy;
    logic [IDX_W-1:0] r_idx;
    logic [LVL_W-1:0] r_red;
    logic [LVL_W-1:0] r_green;
    logic [LVL_W-1:0] r_blue;

    logic [DIV_W-1:0] w_divisor;
    logic [CNT_W-1:0] w_count;
    logic [CNT_W-1:0] w_last_idx;
    logic             w_is_last;
    logic             w_out_fire;
    logic             w_adv;
    logic [NUM_W-1:0] w_phase;
    t_color           w_color;

    t_div_slot w_mod [MOD_STEPS+1];
    t_div_slot w_hue [HUE_STEPS+1];

    // Configuration registers
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= '0;
            r_strip  <= STRIP_RESET;
            r_bright <= FULL_LEVEL;
        end else if (i_cfg.valid) begin
            unique case (t_cfg_idx'(i_cfg.index))
                CFG_PERIOD: r_period <= i_cfg.data[DIV_W-1:0];
                CFG_STRIP:  r_strip  <= i_cfg.data[CNT_W-1:0];
                CFG_BRIGHT: r_bright <= i_cfg.data[LVL_W-1:0];
                default: ;
            endcase
        end
    end

    assign w_divisor = (r_period == '0) ? DEFAULT_PERIOD : r_period;
    assign w_count   = (r_strip > CNT_W'(MAX_LEDS)) ? CNT_W'(MAX_LEDS) : r_strip;

    // Whole pipeline moves together; it stalls only while the pixel stage holds a frame.
    assign w_out_fire = r_busy && o_pix.ready;
    assign w_last_idx = w_count - CNT_W'(1);
    assign w_is_last  = ({1'b0, r_idx} == w_last_idx);
    assign w_adv      = !r_busy || (w_out_fire && w_is_last);
    assign i_in.ready = w_adv;

    // Modulo chain
    assign w_mod[0] = '{valid: i_in.valid, rem: '0, word: i_in.frame_time_ms};

    for (genvar k = 0; k < MOD_STEPS; k++) begin : g_mod
        rhc_div_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_adv     (w_adv),
            .i_divisor (w_divisor),
            .i_slot    (w_mod[k]),
            .o_slot    (w_mod[k+1])
        );
    end

    // phase * 360 as shifts and adds
    assign w_phase = NUM_W'(w_mod[MOD_STEPS].rem);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale_valid <= 1'b0;
        end else if (w_adv) begin
            r_scale_valid <= w_mod[MOD_STEPS].valid;
            r_scale_num   <= (w_phase << 8) + (w_phase << 6) + (w_phase << 5) + (w_phase << 3);
        end
    end

    // Hue quotient < 512, so the top bits already sit below the divisor.
    assign w_hue[0] = '{valid: r_scale_valid,
                        rem:   r_scale_num[NUM_W-1:HUE_W],
                        word:  {r_scale_num[HUE_W-1:0], (DIV_W-HUE_W)'(0)}};

    for (genvar k = 0; k < HUE_STEPS; k++) begin : g_hue
        rhc_div_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_adv     (w_adv),
            .i_divisor (w_divisor),
            .i_slot    (w_hue[k]),
            .o_slot    (w_hue[k+1])
        );
    end

    rhc_color u_color (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_valid (w_hue[HUE_STEPS].valid),
        .i_hue   (w_hue[HUE_STEPS].word[HUE_W-1:0]),
        .i_value (r_bright),
        .o_color (w_color)
    );

    // Pixel output stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (w_adv) begin
            r_busy  <= w_color.valid && (w_count != '0);
            r_idx   <= '0;
            r_red   <= w_color.red;
            r_green <= w_color.green;
            r_blue  <= w_color.blue;
        end else if (w_out_fire) begin
            r_idx <= r_idx + IDX_W'(1);
        end
    end

    assign o_pix.valid       = r_busy;
    assign o_pix.pixel_index = r_idx;
    assign o_pix.red_level   = r_red;
    assign o_pix.green_level = r_green;
    assign o_pix.blue_level  = r_blue;
    assign o_pix.last_pixel  = w_is_last;

    `RHC_ASSERT_NOW(a_idx_in_range, o_pix.valid, {1'b0, o_pix.pixel_index} < w_count)
    `RHC_ASSERT_NOW(a_idle_takes_input, !r_busy, i_in.ready)
    `RHC_ASSERT_NEXT(a_idx_steps, w_out_fire && !w_is_last, r_busy && (r_idx == $past(r_idx) + 1'b1))

endmodule

// File: bench/rainbow_pixel_checker.sv
module rainbow_pixel_checker import rhc_pkg::*; #(
    parameter int MAX_LEDS = 64
) (
    input  logic i_clk,
    input  logic i_rst_n,
    rhc_in_if    i_in,
    rhc_cfg_if   i_cfg,
    rhc_pix_if   i_pix,
    output int   o_fail_count,
    output int   o_pending
);

    localparam int unsigned HUE_SPAN    = 360;
    localparam int unsigned SECTOR_SPAN = 60;

    typedef struct packed {
        logic [IDX_W-1:0] index;
        logic [LVL_W-1:0] red;
        logic [LVL_W-1:0] green;
        logic [LVL_W-1:0] blue;
        logic             last;
    } t_pixel;

    t_pixel           pixels_due[$];
    logic [DIV_W-1:0] period_reg;
    logic [CNT_W-1:0] strip_reg;
    logic [LVL_W-1:0] bright_reg;
    int               fails = 0;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    // Hue from the frame time, then six-sector HSV at full saturation.
    function automatic t_color rainbow_color(input logic [DIV_W-1:0] frame_ms);
        logic [63:0] period;
        logic [63:0] phase;
        logic [63:0] hue;
        logic [63:0] frac;
        logic [63:0] v;
        logic [63:0] fall;
        logic [63:0] rise;
        t_color      c;
        period = (period_reg == '0) ? 64'(DEFAULT_PERIOD) : 64'(period_reg);
        phase  = 64'(frame_ms) % period;
        hue    = phase * HUE_SPAN / period;
        frac   = (hue % SECTOR_SPAN) * FULL_LEVEL / SECTOR_SPAN;
        v      = 64'(bright_reg);
        fall   = v * (FULL_LEVEL - frac) / FULL_LEVEL;
        rise   = v * frac / FULL_LEVEL;
        c.valid = 1'b1;
        case (t_sector'(hue / SECTOR_SPAN))
            SEC_0: begin
                c.red = v[LVL_W-1:0];  c.green = rise[LVL_W-1:0]; c.blue = '0;
            end
            SEC_1: begin
                c.red = fall[LVL_W-1:0]; c.green = v[LVL_W-1:0]; c.blue = '0;
            end
            SEC_2: begin
                c.red = '0; c.green = v[LVL_W-1:0]; c.blue = rise[LVL_W-1:0];
            end
            SEC_3: begin
                c.red = '0; c.green = fall[LVL_W-1:0]; c.blue = v[LVL_W-1:0];
            end
            SEC_4: begin
                c.red = rise[LVL_W-1:0]; c.green = '0; c.blue = v[LVL_W-1:0];
            end
            default: begin
                c.red = v[LVL_W-1:0]; c.green = '0; c.blue = fall[LVL_W-1:0];
            end
        endcase
        return c;
    endfunction

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fails++;
        end
    endfunction

    always @(posedge i_clk) begin : watch
        t_color      c;
        t_pixel      p;
        int unsigned count;
        if (!i_rst_n) begin
            period_reg = '0;
            strip_reg  = STRIP_RESET;
            bright_reg = FULL_LEVEL;
            pixels_due.delete();
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                case (t_cfg_idx'(i_cfg.index))
                    CFG_PERIOD: period_reg = i_cfg.data;
                    CFG_STRIP:  strip_reg  = i_cfg.data[CNT_W-1:0];
                    CFG_BRIGHT: bright_reg = i_cfg.data[LVL_W-1:0];
                    default:    ; // unmapped index: no effect
                endcase
            end
            if (i_in.valid && i_in.ready) begin
                c     = rainbow_color(i_in.frame_time_ms);
                count = (strip_reg > MAX_LEDS) ? MAX_LEDS : strip_reg;
                for (int unsigned i = 0; i < count; i++) begin
                    p.index = i[IDX_W-1:0];
                    p.red   = c.red;
                    p.green = c.green;
                    p.blue  = c.blue;
                    p.last  = (i + 1 == count);
                    pixels_due.push_back(p);
                end
            end
            if (i_pix.valid && i_pix.ready) begin
                if (pixels_due.size() == 0) begin
                    $error("pixel item %0d with no frame pending", i_pix.pixel_index);
                    fails++;
                end else begin
                    p = pixels_due.pop_front();
                    check_field("pixel_index", p.index, i_pix.pixel_index);
                    check_field("red_level", p.red, i_pix.red_level);
                    check_field("green_level", p.green, i_pix.green_level);
                    check_field("blue_level", p.blue, i_pix.blue_level);
                    check_field("last_pixel", p.last, i_pix.last_pixel);
                end
            end
        end
        o_pending    <= pixels_due.size();
        o_fail_count <= fails;
    end

endmodule

// File: bench/tb.sv
module tb;
    import rhc_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam int LONG_HOLD      = 400;
    localparam int DRAIN_CYCLES   = 80;   // margin for frames still in the pipeline
    localparam int STALL_LIMIT    = 4000;
    localparam int BATCHES        = 12;
    localparam int BATCH_ITEMS    = 10;
    localparam int PRESSURE_BATCH = 8;
    localparam int PRESSURE_ITEMS = 50;   // more than the pipeline holds

    logic i_clk = 1'b0;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    int   in_idle_pct;
    int   out_idle_pct;
    bit   pix_hold_req = 1'b0;
    int   quiet_cycles = 0;

    rhc_in_if  in_ch ();
    rhc_cfg_if cfg_ch ();
    rhc_pix_if pix_ch ();

    rainbow_hue_cycle_pixel_fill_unit #(.MAX_LEDS(64)) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .i_cfg   (cfg_ch),
        .o_pix   (pix_ch)
    );

    rainbow_pixel_checker #(.MAX_LEDS(64)) checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (in_ch),
        .i_cfg        (cfg_ch),
        .i_pix        (pix_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (cfg_ch.valid && cfg_ch.ready) ||
            (pix_ch.valid && pix_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("tb failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Pixel receiver: random stalls, plus one long hold on request.
    initial begin
        pix_ch.ready <= 1'b0;
        do @(posedge i_clk); while (i_rst_n !== 1'b1);
        forever begin
            @(posedge i_clk);
            if (pix_hold_req) begin
                pix_hold_req = 1'b0;
                pix_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end else begin
                pix_ch.ready <= ($urandom_range(99) >= out_idle_pct);
            end
        end
    end

    // Leaves valid high; the caller lowers it once the last item is taken.
    task automatic offer_frame(input logic [DIV_W-1:0] frame_ms);
        while ($urandom_range(99) < in_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid         <= 1'b1;
        in_ch.frame_time_ms <= frame_ms;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
    endtask

    task automatic write_setting(input logic [CFG_IDX_W-1:0] idx,
                                 input logic [CFG_DATA_W-1:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
    endtask

    task automatic wait_drained();
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    initial begin : stimulus
        logic [DIV_W-1:0]      period;
        logic [CNT_W-1:0]      strip;
        logic [LVL_W-1:0]      bright;
        logic [CFG_DATA_W-1:0] frame_ms;
        int                    batch_len;
        i_rst_n             <= 1'b0;
        in_ch.valid         <= 1'b0;
        in_ch.frame_time_ms <= '0;
        cfg_ch.valid        <= 1'b0;
        cfg_ch.index        <= '0;
        cfg_ch.data         <= '0;
        in_idle_pct  = 18;
        out_idle_pct = 64;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: default period, full strip, full brightness
        offer_frame(32'd0);
        offer_frame(32'hFFFF_FFFF);
        offer_frame(32'd9999);
        offer_frame(32'd10000);
        in_ch.valid <= 1'b0;
        wait_drained();

        // period 360 makes hue equal the time: walk every sector and its edges
        write_setting(CFG_PERIOD, 32'd360);
        write_setting(CFG_STRIP, 32'd3);
        write_setting(CFG_BRIGHT, 32'd255);
        cfg_ch.valid <= 1'b0;
        for (int h = 0; h <= 360; h += 30) offer_frame(DIV_W'(h));
        offer_frame(32'd59);
        offer_frame(32'd359);
        in_ch.valid <= 1'b0;
        wait_drained();

        // widest period, oversized strip, dark
        write_setting(CFG_PERIOD, 32'hFFFF_FFFF);
        write_setting(CFG_STRIP, 32'd127);
        write_setting(CFG_BRIGHT, 32'd0);
        cfg_ch.valid <= 1'b0;
        offer_frame(32'hFFFF_FFFE);
        offer_frame(32'h7FFF_FFFF);
        in_ch.valid <= 1'b0;
        wait_drained();

        // empty strip, unmapped register index
        write_setting(CFG_PERIOD, 32'd0);
        write_setting(CFG_STRIP, 32'd0);
        write_setting(CFG_UNUSED, 32'hFFFF_FFFF);
        cfg_ch.valid <= 1'b0;
        offer_frame(32'd2500);
        offer_frame(32'hFFFF_FFFF);
        in_ch.valid <= 1'b0;
        wait_drained();

        write_setting(CFG_PERIOD, 32'd1);
        write_setting(CFG_STRIP, 32'd65);
        write_setting(CFG_BRIGHT, 32'd128);
        cfg_ch.valid <= 1'b0;
        offer_frame(32'h1234_5678);
        in_ch.valid <= 1'b0;
        wait_drained();

        for (int b = 0; b < BATCHES; b++) begin
            case (b / 4)
                0: begin in_idle_pct = 18; out_idle_pct = 64; end
                1: begin in_idle_pct = 64; out_idle_pct = 18; end
                default: begin in_idle_pct = 0; out_idle_pct = 0; end
            endcase
            case ($urandom_range(4))
                0: period = '0;
                1: period = 32'd1;
                2: period = 32'd360;
                3: period = $urandom_range(100000, 2);
                default: period = $urandom;
            endcase
            case ($urandom_range(9))
                0: strip = '0;
                1: strip = 7'd64;
                2: strip = CNT_W'($urandom_range(127, 65));
                default: strip = CNT_W'($urandom_range(8, 1));
            endcase
            if (b == PRESSURE_BATCH) strip = 7'd64;
            case ($urandom_range(5))
                0: bright = '0;
                1: bright = 8'd255;
                default: bright = LVL_W'($urandom);
            endcase
            // upper data bits are don't-care for the narrow registers
            write_setting(CFG_PERIOD, period);
            write_setting(CFG_STRIP, ($urandom & ~32'h7F) | strip);
            write_setting(CFG_BRIGHT, ($urandom & ~32'hFF) | bright);
            if ($urandom_range(3) == 0) write_setting(CFG_UNUSED, $urandom);
            cfg_ch.valid <= 1'b0;
            batch_len = (b == PRESSURE_BATCH) ? PRESSURE_ITEMS : BATCH_ITEMS;
            if (b == PRESSURE_BATCH) pix_hold_req = 1'b1;
            for (int n = 0; n < batch_len; n++) begin
                frame_ms = ($urandom_range(3) == 0) ? $urandom_range(20000) : $urandom;
                offer_frame(frame_ms);
            end
            in_ch.valid <= 1'b0;
            wait_drained();
        end

        if (fail_count == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

endmodule

// File: rainbow_hue_cycle_pixel_fill_unit.f
+incdir+hdl
hdl/rhc_pkg.sv
hdl/rhc_ifs.sv
hdl/rhc_div_cell.sv
hdl/rhc_color.sv
hdl/rainbow_hue_cycle_pixel_fill_unit.sv
bench/rainbow_pixel_checker.sv
bench/tb.sv
